// ===== rtl/dls_pkg.sv =====
package dls_pkg;

    localparam int MAX_INSTRUCTIONS = 64;
    localparam int MAX_SOURCES      = 4;
    localparam int SRC_FIELDS       = 4;
    localparam int IDX_W            = 6;
    localparam int TENSOR_AW        = 8;
    localparam int TENSOR_DEPTH     = 256;

    localparam logic [1:0] ST_SCHED    = 2'd0;
    localparam logic [1:0] ST_UNSAT    = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic                           dead;
        logic signed [8:0]              dest;
        logic [2:0]                     count;
        logic [SRC_FIELDS-1:0][8:0]     src;
    } t_instr;

    typedef struct packed {
        logic                           valid;
        logic [IDX_W-1:0]               idx;
    } t_prod;

    typedef struct packed {
        logic                           dead;
        logic                           blocked;
        logic [SRC_FIELDS-1:0]          active;
        logic [SRC_FIELDS-1:0]          pvalid;
        logic [SRC_FIELDS-1:0][IDX_W-1:0] pidx;
    } t_dep;

endpackage

// ===== rtl/dls_if.sv =====
interface dls_in_if;
    logic              valid;
    logic              ready;
    logic              is_dead;
    logic signed [8:0] dest_tensor;
    logic [2:0]        source_count;
    logic signed [8:0] source_a;
    logic signed [8:0] source_b;
    logic signed [8:0] source_c;
    logic signed [8:0] source_d;
    logic              final_instruction;

    modport source (output valid, is_dead, dest_tensor, source_count, source_a, source_b,
                    source_c, source_d, final_instruction, input ready);
    modport sink   (input valid, is_dead, dest_tensor, source_count, source_a, source_b,
                    source_c, source_d, final_instruction, output ready);
endinterface

interface dls_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] instr_index;
    logic [1:0] status;
    logic       run_end;

    modport source (output valid, instr_index, status, run_end, input ready);
    modport sink   (input valid, instr_index, status, run_end, output ready);
endinterface

// ===== rtl/dataflow_list_scheduler.sv =====
// load: each input transfer is followed by a wait state; a final item adds a
// resolve pass over each loaded instruction and its sources, then each result
// takes a table scan through the shared evaluation unit plus the output transfer
// one item at a time: the input is not ready while loading, resolving or scanning
// after reset and after each schedule a pass clears all 256 producer entries;
// the input is not ready during it
module dataflow_list_scheduler #(
    parameter int MAX_INSTRUCTIONS = dls_pkg::MAX_INSTRUCTIONS,
    parameter int MAX_SOURCES      = dls_pkg::MAX_SOURCES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dls_in_if.sink            i_in,
    dls_out_if.source         o_out
);
    localparam int N  = MAX_INSTRUCTIONS;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam int CLAMP_I = (MAX_SOURCES < dls_pkg::SRC_FIELDS) ? MAX_SOURCES
                                                                  : dls_pkg::SRC_FIELDS;
    localparam logic [2:0] CLAMP = 3'(CLAMP_I);
    localparam int MW = 2 ** dls_pkg::IDX_W;
    localparam int TAW = dls_pkg::TENSOR_AW;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LWAIT = 4'd2;
    localparam logic [3:0] S_RRD   = 4'd3;
    localparam logic [3:0] S_RENT  = 4'd4;
    localparam logic [3:0] S_RSRC  = 4'd5;
    localparam logic [3:0] S_RCAP  = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]               r_st;
    logic [TAW-1:0]           r_clr;
    logic [CW-1:0]            r_loaded;
    logic [CW-1:0]            r_live;
    logic [CW-1:0]            r_scnt;
    logic                     r_ovf;
    logic                     r_final;
    logic                     r_lwr;
    logic [TAW-1:0]           r_ldest;
    logic [dls_pkg::IDX_W-1:0] r_lidx;
    logic [CW-1:0]            r_i;
    logic [1:0]               r_k;
    dls_pkg::t_instr          r_ent;
    dls_pkg::t_dep            r_dep;
    logic                     r_pv;
    logic [dls_pkg::IDX_W-1:0] r_pi;
    logic                     r_found;
    logic [dls_pkg::IDX_W-1:0] r_best;
    logic [2:0]               r_bscore;
    logic [MW-1:0]            r_mask;
    logic [dls_pkg::IDX_W-1:0] r_prev;
    logic                     r_prev_v;
    logic                     r_done;
    logic [5:0]               r_oidx;
    logic [1:0]               r_ost;
    logic                     r_oend;

    logic                     in_xfer;
    logic                     out_xfer;
    logic [2:0]               cnt_clamped;
    dls_pkg::t_instr          in_ent;
    dls_pkg::t_instr          instr_rd;
    dls_pkg::t_prod           prod_rd;
    dls_pkg::t_prod           prod_wd;
    logic                     prod_we;
    logic [TAW-1:0]           prod_wa;
    logic [TAW-1:0]           prod_ra;
    dls_pkg::t_dep            dep_rd;
    dls_pkg::t_dep            dep_new;
    logic                     ev_ready;
    logic [2:0]               ev_score;
    logic                     last_pick;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_st == S_IDLE);
    assign o_out.valid = (r_st == S_OUT);
    assign o_out.instr_index = r_oidx;
    assign o_out.status      = r_ost;
    assign o_out.run_end     = r_oend;

    always_comb begin
        cnt_clamped = (i_in.source_count > CLAMP) ? CLAMP : i_in.source_count;
        in_ent.dead  = i_in.is_dead;
        in_ent.dest  = i_in.dest_tensor;
        in_ent.count = cnt_clamped;
        in_ent.src[0] = i_in.source_a;
        in_ent.src[1] = i_in.source_b;
        in_ent.src[2] = i_in.source_c;
        in_ent.src[3] = i_in.source_d;
    end

    dls_ram #(.W($bits(dls_pkg::t_instr)), .D(N)) u_instr_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && (r_loaded < CW'(N))),
        .i_waddr (r_loaded[IW-1:0]),
        .i_wdata (in_ent),
        .i_raddr (r_i[IW-1:0]),
        .o_rdata (instr_rd)
    );

    always_comb begin
        prod_we = 1'b0;
        prod_wa = r_clr;
        prod_wd = '0;
        if (r_st == S_CLEAR) begin
            prod_we = 1'b1;
        end else if (r_st == S_LWAIT && r_lwr && !prod_rd.valid) begin
            prod_we = 1'b1;
            prod_wa = r_ldest;
            prod_wd.valid = 1'b1;
            prod_wd.idx   = r_lidx;
        end
        prod_ra = (r_st == S_IDLE) ? i_in.dest_tensor[TAW-1:0] : r_ent.src[r_k][TAW-1:0];
    end

    dls_ram #(.W($bits(dls_pkg::t_prod)), .D(dls_pkg::TENSOR_DEPTH)) u_prod_ram (
        .i_clk   (i_clk),
        .i_we    (prod_we),
        .i_waddr (prod_wa),
        .i_wdata (prod_wd),
        .i_raddr (prod_ra),
        .o_rdata (prod_rd)
    );

    always_comb begin
        dep_new = r_dep;
        dep_new.active[r_k] = ({1'b0, r_k} < r_ent.count);
        dep_new.pvalid[r_k] = prod_rd.valid;
        dep_new.pidx[r_k]   = prod_rd.idx;
        if (dep_new.active[r_k] && r_ent.src[r_k][8]) begin
            dep_new.blocked = 1'b1;
        end
    end

    dls_ram #(.W($bits(dls_pkg::t_dep)), .D(N)) u_dep_ram (
        .i_clk   (i_clk),
        .i_we    (r_st == S_RCAP && r_k == 2'd3),
        .i_waddr (r_i[IW-1:0]),
        .i_wdata (dep_new),
        .i_raddr (r_i[IW-1:0]),
        .o_rdata (dep_rd)
    );

    dls_eval u_eval (
        .i_dep    (dep_rd),
        .i_mask   (r_mask),
        .i_idx    (r_pi),
        .i_prev   (r_prev),
        .i_prev_v (r_prev_v),
        .o_ready  (ev_ready),
        .o_score  (ev_score)
    );

    assign last_pick = (CW'(r_scnt + 1'b1) == r_live);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLEAR;
            r_clr    <= '0;
            r_loaded <= '0;
            r_live   <= '0;
            r_scnt   <= '0;
            r_ovf    <= 1'b0;
            r_final  <= 1'b0;
            r_lwr    <= 1'b0;
            r_i      <= '0;
            r_k      <= '0;
            r_pv     <= 1'b0;
            r_found  <= 1'b0;
            r_mask   <= '0;
            r_prev_v <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            case (r_st)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_final <= i_in.final_instruction;
                        r_ldest <= i_in.dest_tensor[TAW-1:0];
                        r_lidx  <= dls_pkg::IDX_W'(r_loaded);
                        r_lwr   <= 1'b0;
                        if (r_loaded < CW'(N)) begin
                            r_loaded <= r_loaded + 1'b1;
                            if (!i_in.is_dead) begin
                                r_live <= r_live + 1'b1;
                                r_lwr  <= !i_in.dest_tensor[8];
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_st <= S_LWAIT;
                    end
                end
                S_LWAIT: begin
                    r_i <= '0;
                    if (!r_final) begin
                        r_st <= S_IDLE;
                    end else if (r_ovf) begin
                        r_oidx <= '0;
                        r_ost  <= dls_pkg::ST_OVERFLOW;
                        r_oend <= 1'b1;
                        r_done <= 1'b1;
                        r_st   <= S_OUT;
                    end else if (r_live == '0) begin
                        r_oidx <= '0;
                        r_ost  <= dls_pkg::ST_EMPTY;
                        r_oend <= 1'b1;
                        r_done <= 1'b1;
                        r_st   <= S_OUT;
                    end else begin
                        r_st <= S_RRD;
                    end
                end
                S_RRD: begin
                    r_st <= S_RENT;
                end
                S_RENT: begin
                    r_ent       <= instr_rd;
                    r_dep       <= '{dead: instr_rd.dead, default: '0};
                    r_k         <= '0;
                    r_st        <= S_RSRC;
                end
                S_RSRC: begin
                    r_st <= S_RCAP;
                end
                S_RCAP: begin
                    r_dep <= dep_new;
                    if (r_k == 2'd3) begin
                        if (CW'(r_i + 1'b1) == r_loaded) begin
                            r_i     <= '0;
                            r_pv    <= 1'b0;
                            r_found <= 1'b0;
                            r_st    <= S_SCAN;
                        end else begin
                            r_i  <= r_i + 1'b1;
                            r_st <= S_RRD;
                        end
                    end else begin
                        r_k  <= r_k + 1'b1;
                        r_st <= S_RSRC;
                    end
                end
                S_SCAN: begin
                    if (r_pv && ev_ready && (!r_found || ev_score > r_bscore)) begin
                        r_found  <= 1'b1;
                        r_best   <= r_pi;
                        r_bscore <= ev_score;
                    end
                    if (r_i != r_loaded) begin
                        r_pv <= 1'b1;
                        r_pi <= dls_pkg::IDX_W'(r_i);
                        r_i  <= r_i + 1'b1;
                    end else if (r_pv) begin
                        r_pv <= 1'b0;
                    end else if (!r_found) begin
                        r_oidx <= '0;
                        r_ost  <= dls_pkg::ST_UNSAT;
                        r_oend <= 1'b1;
                        r_done <= 1'b1;
                        r_st   <= S_OUT;
                    end else begin
                        r_mask[r_best] <= 1'b1;
                        r_prev         <= r_best;
                        r_prev_v       <= 1'b1;
                        r_scnt         <= r_scnt + 1'b1;
                        r_oidx         <= 6'(r_best);
                        r_ost          <= dls_pkg::ST_SCHED;
                        r_oend         <= last_pick;
                        r_done         <= last_pick;
                        r_st           <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_xfer) begin
                        r_i     <= '0;
                        r_pv    <= 1'b0;
                        r_found <= 1'b0;
                        if (r_done) begin
                            r_clr    <= '0;
                            r_loaded <= '0;
                            r_live   <= '0;
                            r_scnt   <= '0;
                            r_ovf    <= 1'b0;
                            r_mask   <= '0;
                            r_prev_v <= 1'b0;
                            r_done   <= 1'b0;
                            r_st     <= S_CLEAR;
                        end else begin
                            r_st <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_st <= S_CLEAR;
                end
            endcase
        end
    end
endmodule

// ===== rtl/dls_ram.sv =====
module dls_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/dls_eval.sv =====
module dls_eval (
    input  dls_pkg::t_dep                    i_dep,
    input  logic [2**dls_pkg::IDX_W-1:0]     i_mask,
    input  logic [dls_pkg::IDX_W-1:0]        i_idx,
    input  logic [dls_pkg::IDX_W-1:0]        i_prev,
    input  logic                             i_prev_v,
    output logic                             o_ready,
    output logic [2:0]                       o_score
);
    always_comb begin
        o_ready = !i_dep.dead && !i_dep.blocked && !i_mask[i_idx];
        o_score = 3'd0;
        for (int k = 0; k < dls_pkg::SRC_FIELDS; k++) begin
            if (i_dep.active[k] && i_dep.pvalid[k]) begin
                if (!i_mask[i_dep.pidx[k]]) begin
                    o_ready = 1'b0;
                end
                if (i_prev_v && i_dep.pidx[k] == i_prev) begin
                    o_score = o_score + 3'd1;
                end
            end
        end
    end
endmodule

// ===== dv/dataflow_list_scheduler_sb.sv =====
`timescale 1ns / 100ps

package dataflow_list_scheduler_sb_pkg;

    typedef struct {
        bit              dead;
        logic signed [8:0] dest;
        int unsigned     count;
        logic signed [8:0] src[4];
    } instr_t;

    typedef struct {
        logic [5:0] idx;
        logic [1:0] status;
        logic       run_end;
    } sched_res_t;

    class schedule_scoreboard;
        instr_t       program_q[$];
        bit           overflowed;
        sched_res_t   pending_q[$];
        int           errors;

        function int first_writer(logic signed [8:0] t);
            foreach (program_q[i])
                if (!program_q[i].dead && program_q[i].dest == t) return i;
            return -1;
        endfunction

        function void push(logic [5:0] idx, logic [1:0] st, logic e);
            sched_res_t r;
            r.idx = idx;
            r.status = st;
            r.run_end = e;
            pending_q.push_back(r);
        endfunction

        function void note_instr(bit dead, logic signed [8:0] dest, logic [2:0] cnt,
                                 logic signed [8:0] a, logic signed [8:0] b,
                                 logic signed [8:0] c, logic signed [8:0] d, bit fin);
            instr_t e;
            bit done[64];
            int live, nsched, prev, best, top_score, score, p;
            bit ok;
            if (program_q.size() < dls_pkg::MAX_INSTRUCTIONS) begin
                e.dead = dead;
                e.dest = dest;
                e.count = (cnt > dls_pkg::MAX_SOURCES) ? dls_pkg::MAX_SOURCES : cnt;
                e.src[0] = a;
                e.src[1] = b;
                e.src[2] = c;
                e.src[3] = d;
                program_q.push_back(e);
            end else begin
                overflowed = 1;
            end
            if (!fin) return;
            live = 0;
            nsched = 0;
            prev = -1;
            foreach (program_q[i]) if (!program_q[i].dead) live++;
            if (overflowed) push(0, dls_pkg::ST_OVERFLOW, 1);
            else if (live == 0) push(0, dls_pkg::ST_EMPTY, 1);
            else begin
                while (nsched < live) begin
                    best = -1;
                    top_score = -1;
                    foreach (program_q[i]) begin
                        if (program_q[i].dead || done[i]) continue;
                        ok = 1;
                        score = 0;
                        for (int k = 0; k < program_q[i].count; k++) begin
                            if (program_q[i].src[k] < 0) begin
                                ok = 0;
                                break;
                            end
                            p = first_writer(program_q[i].src[k]);
                            if (p >= 0 && !done[p]) begin
                                ok = 0;
                                break;
                            end
                            if (prev >= 0 && p == prev) score++;
                        end
                        if (ok && score > top_score) begin
                            best = i;
                            top_score = score;
                        end
                    end
                    if (best < 0) begin
                        push(0, dls_pkg::ST_UNSAT, 1);
                        break;
                    end
                    done[best] = 1;
                    prev = best;
                    nsched++;
                    push(best[5:0], dls_pkg::ST_SCHED, nsched == live);
                end
            end
            program_q.delete();
            overflowed = 0;
        endfunction

        function void check_result(logic [5:0] idx, logic [1:0] st, logic e);
            sched_res_t x;
            if (pending_q.size() == 0) begin
                $error("unexpected result idx=%0d status=%0d", idx, st);
                errors++;
                return;
            end
            x = pending_q.pop_front();
            if (idx !== x.idx) begin
                $error("instr_index expected %0d actual %0d", x.idx, idx);
                errors++;
            end
            if (st !== x.status) begin
                $error("status expected %0d actual %0d", x.status, st);
                errors++;
            end
            if (e !== x.run_end) begin
                $error("run_end expected %0d actual %0d", x.run_end, e);
                errors++;
            end
        endfunction
    endclass
endpackage

// ===== dv/dataflow_list_scheduler_tb.sv =====
`timescale 1ns / 100ps

module dataflow_list_scheduler_tb;

    logic i_clk = 0;
    logic i_rst_n = 0;
    dls_in_if  in_if();
    dls_out_if out_if();

    dataflow_list_scheduler dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    dataflow_list_scheduler_sb_pkg::schedule_scoreboard sb = new();
    int sent;
    bit calm;
    int hold_cycles;

    function automatic logic signed [8:0] rand_tensor(int hi);
        if ($urandom_range(0, 30) == 0) return -9'sd1;
        if ($urandom_range(0, 40) == 0) return 9'sd255;
        return 9'($urandom_range(0, hi));
    endfunction

    task automatic send_instr(bit dead, logic signed [8:0] dest, logic [2:0] cnt,
                              logic signed [8:0] a, logic signed [8:0] b,
                              logic signed [8:0] c, logic signed [8:0] d, bit fin);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 21) begin
            in_if.valid <= 0;
            @(negedge i_clk);
        end
        in_if.valid <= 1;
        in_if.is_dead <= dead;
        in_if.dest_tensor <= dest;
        in_if.source_count <= cnt;
        in_if.source_a <= a;
        in_if.source_b <= b;
        in_if.source_c <= c;
        in_if.source_d <= d;
        in_if.final_instruction <= fin;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_instr(dead, dest, cnt, a, b, c, d, fin);
        sent++;
    endtask

    task automatic send_program(int len, int hi, int dead_pct);
        for (int i = 0; i < len; i++)
            send_instr($urandom_range(0, 99) < dead_pct,
                       ($urandom_range(0, 15) == 0) ? -9'sd1 : 9'($urandom_range(0, hi)),
                       3'($urandom_range(0, 7)), rand_tensor(hi), rand_tensor(hi),
                       rand_tensor(hi), rand_tensor(hi), i == len - 1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            sb.check_result(out_if.instr_index, out_if.status, out_if.run_end);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 0;
        else if (hold_cycles > 0) begin
            out_if.ready <= 0;
            hold_cycles--;
        end else out_if.ready <= calm || ($urandom_range(0, 99) >= 21);
    end

    initial begin
        #200_000_000;
        $display("dataflow_list_scheduler_tb: FAIL");
        $finish;
    end

    initial begin
        in_if.valid = 0;
        in_if.is_dead = 0;
        in_if.dest_tensor = 0;
        in_if.source_count = 0;
        in_if.source_a = 0;
        in_if.source_b = 0;
        in_if.source_c = 0;
        in_if.source_d = 0;
        in_if.final_instruction = 0;
        out_if.ready = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // chain with a duplicate source and a dead shadowing producer
        send_instr(0, 9'sd10, 0, 0, 0, 0, 0, 0);
        send_instr(1, 9'sd11, 0, 0, 0, 0, 0, 0);
        send_instr(0, 9'sd11, 2, 9'sd10, 9'sd10, 0, 0, 0);
        send_instr(0, -9'sd1, 7, 9'sd11, 9'sd10, 9'sd11, 9'sd10, 0);
        send_instr(0, 9'sd255, 1, 9'sd255, 0, 0, 0, 1);
        drain();
        // no live instructions
        send_instr(1, 9'sd3, 0, 0, 0, 0, 0, 0);
        send_instr(1, -9'sd1, 4, -9'sd1, -9'sd1, -9'sd1, -9'sd1, 1);
        drain();
        // negative source stalls
        send_instr(0, 9'sd1, 1, -9'sd1, 0, 0, 0, 1);
        drain();
        // cyclic dependency stalls
        send_instr(0, 9'sd1, 1, 9'sd2, 0, 0, 0, 0);
        send_instr(0, 9'sd2, 5, 9'sd1, 9'sd1, 9'sd1, 9'sd1, 1);
        drain();
        // overflow
        for (int i = 0; i < 66; i++)
            send_instr(0, 9'(i), 0, 0, 0, 0, 0, i == 65);
        drain();
        // full table of 64
        send_program(64, 63, 10);
        drain();

        // receiver holds off while the sender keeps offering
        fork
            begin
                @(negedge i_clk);
                hold_cycles = 3000;
            end
            begin
                for (int p = 0; p < 4; p++) send_program(3, 5, 10);
            end
        join
        drain();

        while (sent < 500) begin
            if ($urandom_range(0, 9) == 0) begin
                calm = 1;
                send_program(20, 20, 5);
                calm = 0;
            end else if ($urandom_range(0, 3) == 0) send_program($urandom_range(1, 6), 60, 30);
            else send_program($urandom_range(2, 12), $urandom_range(3, 12), 15);
            if ($urandom_range(0, 9) == 0) drain();
        end
        drain();
        repeat (1000) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("dataflow_list_scheduler_tb: PASS");
        else
            $display("dataflow_list_scheduler_tb: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/dls_pkg.sv
rtl/dls_if.sv
rtl/dls_ram.sv
rtl/dls_eval.sv
rtl/dataflow_list_scheduler.sv
dv/dataflow_list_scheduler_sb.sv
dv/dataflow_list_scheduler_tb.sv
